### rtl/core/cwt_pkg.sv
`timescale 1ns / 1ps

package cwt_pkg;

    localparam int TAG_BITS  = 16;
    localparam int TIME_BITS = 32;
    localparam int MIN_BITS  = 16;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [MIN_BITS-1:0] MIN_INTERVAL_RESET = MIN_BITS'(1000);

    // Register index of min_interval (byte address bits above the word offset).
    localparam logic REG_MIN_INTERVAL = 1'b0;

    // Event kinds.
    localparam logic [2:0] KIND_REQUEST  = 3'd0;
    localparam logic [2:0] KIND_STARTED  = 3'd1;
    localparam logic [2:0] KIND_COMPLETE = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_CLOSE    = 3'd4;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_DISPATCH     = 3'd1,
        ACT_STARTED      = 3'd2,
        ACT_DEFERRED     = 3'd3,
        ACT_QUEUED       = 3'd4,
        ACT_DROP_CLOSED  = 3'd5,
        ACT_DROP_PENDING = 3'd6,
        ACT_IDLE         = 3'd7
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [TAG_BITS-1:0] tag;
        logic                protocol_error;
    } result_t;

endpackage

### rtl/core/cwt_apb_regs.sv
`timescale 1ns / 1ps

module cwt_apb_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cwt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cwt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic [cwt_pkg::MIN_BITS-1:0]       min_interval
);
    import cwt_pkg::*;

    logic [MIN_BITS-1:0] min_interval_reg;
    logic                reg_sel;

    assign reg_sel = (paddr[APB_ADDR_BITS-1] == REG_MIN_INTERVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RESET;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            min_interval_reg <= pwdata[MIN_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = {{(APB_DATA_BITS-MIN_BITS){1'b0}}, min_interval_reg};
        end
    end

    assign min_interval = min_interval_reg;

endmodule

### rtl/core/cwt_core.sv
`timescale 1ns / 1ps

module cwt_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [2:0]                     kind,
    input  logic [cwt_pkg::TAG_BITS-1:0]   activity_tag,
    input  logic [cwt_pkg::MIN_BITS-1:0]   min_interval,
    output cwt_pkg::result_t               result
);
    import cwt_pkg::*;

    logic                 executing_reg, executing_next;
    logic                 pending_reg, pending_next;
    logic                 awaiting_reg, awaiting_next;
    logic                 closed_reg, closed_next;
    logic                 ever_started_reg, ever_started_next;
    logic                 timer_armed_reg, timer_armed_next;
    logic [TAG_BITS-1:0]  pending_tag_reg, pending_tag_next;
    logic [TAG_BITS-1:0]  running_tag_reg, running_tag_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] last_start_reg, last_start_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;

    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] min_wide;
    logic [TIME_BITS-1:0] now_inc;
    logic                 may_start;

    assign min_wide  = {{(TIME_BITS-MIN_BITS){1'b0}}, min_interval};
    assign elapsed   = now_reg - last_start_reg;
    assign now_inc   = now_reg + TIME_BITS'(1);
    assign may_start = !ever_started_reg || (elapsed >= min_wide);

    always_comb
    begin
        executing_next    = executing_reg;
        pending_next      = pending_reg;
        awaiting_next     = awaiting_reg;
        closed_next       = closed_reg;
        ever_started_next = ever_started_reg;
        timer_armed_next  = timer_armed_reg;
        pending_tag_next  = pending_tag_reg;
        running_tag_next  = running_tag_reg;
        now_next          = now_reg;
        last_start_next   = last_start_reg;
        deadline_next     = deadline_reg;
        result            = '{action: ACT_NONE, tag: '0, protocol_error: 1'b0};

        case (kind)
            KIND_REQUEST:
            begin
                result.tag = activity_tag;
                if (closed_reg)
                begin
                    result.action = ACT_DROP_CLOSED;
                end
                else if (pending_reg)
                begin
                    result.action = ACT_DROP_PENDING;
                end
                else if (executing_reg)
                begin
                    pending_tag_next = activity_tag;
                    pending_next     = 1'b1;
                    result.action    = ACT_QUEUED;
                end
                else if (may_start)
                begin
                    executing_next   = 1'b1;
                    pending_next     = 1'b0;
                    running_tag_next = activity_tag;
                    result.action    = ACT_DISPATCH;
                end
                else
                begin
                    pending_tag_next = activity_tag;
                    executing_next   = 1'b0;
                    pending_next     = 1'b1;
                    deadline_next    = last_start_reg + min_wide;
                    timer_armed_next = 1'b1;
                    result.action    = ACT_DEFERRED;
                end
            end
            KIND_STARTED:
            begin
                result.tag = running_tag_reg;
                if (!executing_reg || awaiting_reg)
                begin
                    result.protocol_error = 1'b1;
                end
                else
                begin
                    last_start_next   = now_reg;
                    awaiting_next     = 1'b1;
                    ever_started_next = 1'b1;
                    result.action     = ACT_STARTED;
                end
            end
            KIND_COMPLETE:
            begin
                result.tag = running_tag_reg;
                if (!executing_reg || !awaiting_reg)
                begin
                    result.protocol_error = 1'b1;
                end
                else
                begin
                    awaiting_next = 1'b0;
                    if (pending_reg)
                    begin
                        if (closed_reg)
                        begin
                            result.action = ACT_DROP_CLOSED;
                        end
                        else
                        begin
                            // The held request either starts now or waits on the timer;
                            // in both cases it is the tag that the result reports.
                            result.tag = pending_tag_reg;
                            if (may_start)
                            begin
                                executing_next   = 1'b1;
                                pending_next     = 1'b0;
                                running_tag_next = pending_tag_reg;
                                result.action    = ACT_DISPATCH;
                            end
                            else
                            begin
                                executing_next   = 1'b0;
                                pending_next     = 1'b1;
                                deadline_next    = last_start_reg + min_wide;
                                timer_armed_next = 1'b1;
                                result.action    = ACT_DEFERRED;
                            end
                        end
                    end
                    else
                    begin
                        executing_next = 1'b0;
                        result.action  = ACT_IDLE;
                    end
                end
            end
            KIND_TICK:
            begin
                now_next = now_inc;
                if (timer_armed_reg && (now_inc == deadline_reg))
                begin
                    timer_armed_next = 1'b0;
                    if (executing_reg || !pending_reg)
                    begin
                        result.protocol_error = 1'b1;
                        result.tag            = running_tag_reg;
                    end
                    else if (closed_reg)
                    begin
                        result.action = ACT_DROP_CLOSED;
                        result.tag    = running_tag_reg;
                    end
                    else
                    begin
                        pending_next     = 1'b0;
                        executing_next   = 1'b1;
                        running_tag_next = pending_tag_reg;
                        result.action    = ACT_DISPATCH;
                        result.tag       = pending_tag_reg;
                    end
                end
            end
            KIND_CLOSE:
            begin
                closed_next      = 1'b1;
                timer_armed_next = 1'b0;
            end
            default:
            begin
                result.action = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            executing_reg    <= 1'b0;
            pending_reg      <= 1'b0;
            awaiting_reg     <= 1'b0;
            closed_reg       <= 1'b0;
            ever_started_reg <= 1'b0;
            timer_armed_reg  <= 1'b0;
            pending_tag_reg  <= '0;
            running_tag_reg  <= '0;
            now_reg          <= '0;
            last_start_reg   <= '0;
            deadline_reg     <= '0;
        end
        else if (step)
        begin
            executing_reg    <= executing_next;
            pending_reg      <= pending_next;
            awaiting_reg     <= awaiting_next;
            closed_reg       <= closed_next;
            ever_started_reg <= ever_started_next;
            timer_armed_reg  <= timer_armed_next;
            pending_tag_reg  <= pending_tag_next;
            running_tag_reg  <= running_tag_next;
            now_reg          <= now_next;
            last_start_reg   <= last_start_next;
            deadline_reg     <= deadline_next;
        end
    end

endmodule

### rtl/core/coalescing_work_throttle_top.sv
`timescale 1ns / 1ps

// Coalescing work throttle. Each request on the input channel is one event
// (work request with a tag, work started, work complete, time tick or close),
// and each produces exactly one result request carrying an action code, the
// tag the action concerns and a protocol-error flag. An event is evaluated in
// the cycle it is accepted and its result appears in the output register on
// the next cycle, so the block takes one event per cycle for as long as the
// output side keeps up. The output register is the only thing that gates
// throughput: a new event is taken whenever the register is empty or its
// result is being taken in the same cycle. min_interval is written through
// the APB port at byte address 0 and reads back there; it should only be
// changed while no event is in flight.
module coalescing_work_throttle_top (
    input  logic                               clk,
    input  logic                               rst_n,

    // Event channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [2:0]                         kind,
    input  logic [cwt_pkg::TAG_BITS-1:0]       activity_tag,

    // Result channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         action,
    output logic [cwt_pkg::TAG_BITS-1:0]       result_tag,
    output logic                               protocol_error,

    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cwt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cwt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import cwt_pkg::*;

    logic [MIN_BITS-1:0] min_interval;
    logic                step;
    result_t             result;
    result_t             out_data_reg;
    logic                out_valid_reg;

    assign pready = 1'b1;

    cwt_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .min_interval (min_interval)
    );

    // The output register can take a new result when it is empty or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    cwt_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .kind         (kind),
        .activity_tag (activity_tag),
        .min_interval (min_interval),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // Payload register needs no reset; it is only looked at while out_valid is high.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = out_data_reg.action;
    assign result_tag     = out_data_reg.tag;
    assign protocol_error = out_data_reg.protocol_error;

endmodule

### rtl/core/cwt_checker.sv
`timescale 1ns / 1ps

module cwt_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [2:0]                     kind,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [2:0]                     action,
    input  logic [cwt_pkg::TAG_BITS-1:0]   result_tag,
    input  logic                           protocol_error
);
    import cwt_pkg::*;

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(result_tag)
            && $stable(protocol_error))
    else $error("result changed while stalled");

    // Every accepted request yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

    // A sequencing error never comes with an action.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && protocol_error |-> action == ACT_NONE)
    else $error("protocol error reported with an action");

    // Close reports nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_CLOSE |=>
            action == ACT_NONE && result_tag == '0 && !protocol_error)
    else $error("close produced a non-empty result");

    // Undefined kinds are ignored silently.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == 3'd5 || kind == 3'd6 || kind == 3'd7) |=>
            action == ACT_NONE && result_tag == '0 && !protocol_error)
    else $error("undefined event kind produced a result");

endmodule

bind coalescing_work_throttle_top cwt_checker u_cwt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .action         (action),
    .result_tag     (result_tag),
    .protocol_error (protocol_error)
);
